[design/slfl_pkg.sv]
// Shared types, constants and helper functions of the serial flash loader command parser.
// No dependencies; every other design file imports this package.
package slfl_pkg;

   // Flash geometry.
   localparam int FLASH_BYTES  = 131072;
   localparam int PAGE_BYTES   = 256;
   localparam int LOADER_WORDS = 4096;

   localparam int ADDR_W   = 17;
   localparam int TAIL_MAX = 6;
   localparam int TCNT_W   = 3;

   // Application area: everything below the loader, rounded up to a page for the
   // address that follows an erase.
   localparam int APP_SIZE = (2 * LOADER_WORDS > FLASH_BYTES) ? 0
                           : FLASH_BYTES - 2 * LOADER_WORDS;
   localparam int APP_END  = ((APP_SIZE + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;
   localparam logic [ADDR_W-1:0] APP_SIZE_ADDR = APP_SIZE[ADDR_W-1:0];
   localparam logic [ADDR_W-1:0] APP_END_ADDR  = APP_END[ADDR_W-1:0];

   // Command codes.
   localparam logic [7:0] CMD_SET_ADDR   = 8'h41; // 'A'
   localparam logic [7:0] CMD_LOW_BYTE   = 8'h63; // 'c'
   localparam logic [7:0] CMD_HIGH_BYTE  = 8'h43; // 'C'
   localparam logic [7:0] CMD_BURST      = 8'h4D; // 'M'
   localparam logic [7:0] CMD_DEV_TYPE   = 8'h54; // 'T'
   localparam logic [7:0] CMD_ERASE      = 8'h65; // 'e'
   localparam logic [7:0] CMD_PAGE_WRITE = 8'h6D; // 'm'
   localparam logic [7:0] CMD_PROG_ENTER = 8'h50; // 'P'
   localparam logic [7:0] CMD_PROG_LEAVE = 8'h4C; // 'L'
   localparam logic [7:0] CMD_AUTO_INC   = 8'h61; // 'a'
   localparam logic [7:0] CMD_BLOCK_SUP  = 8'h6E; // 'n'
   localparam logic [7:0] CMD_SW_IDENT   = 8'h53; // 'S'
   localparam logic [7:0] CMD_SIGNATURE  = 8'h73; // 's'
   localparam logic [7:0] CMD_DEV_LIST   = 8'h74; // 't'
   localparam logic [7:0] CMD_SW_VER     = 8'h56; // 'V'
   localparam logic [7:0] CMD_HW_VER     = 8'h76; // 'v'
   localparam logic [7:0] CMD_START_APP  = 8'h5A; // 'Z'

   // Reply bytes.
   localparam logic [7:0] RPL_CR      = 8'h0D;
   localparam logic [7:0] RPL_YES     = 8'h59; // 'Y'
   localparam logic [7:0] RPL_UNKNOWN = 8'h3F; // '?'
   localparam logic [7:0] RPL_DEV_ID  = 8'h44;
   localparam logic [7:0] RPL_SIG0    = 8'h02;
   localparam logic [7:0] RPL_SIG1    = 8'h97;
   localparam logic [7:0] RPL_SIG2    = 8'h1E;

   localparam logic [6:0][7:0] SW_IDENT = {8'h54, 8'h4F, 8'h4F, 8'h42, 8'h52, 8'h56, 8'h41};

   typedef enum logic [2:0] {
      FC_NONE       = 3'd0,
      FC_FILL       = 3'd1,
      FC_ERASE      = 3'd2,
      FC_PAGE_WRITE = 3'd3,
      FC_START_APP  = 3'd4
   } flash_cmd_type;

   typedef logic [TAIL_MAX-1:0][7:0] tail_type;

   typedef struct packed {
      logic              reply_valid;
      logic [7:0]        reply_byte;
      flash_cmd_type     flash_cmd;
      logic [ADDR_W-1:0] flash_address;
      logic [15:0]       flash_word;
   } result_type;

   // One parsed byte's worth of results: a head result and up to six reply bytes.
   typedef struct packed {
      logic              valid;
      result_type        head;
      tail_type          tail;
      logic [TCNT_W-1:0] tail_cnt;
   } desc_type;

   function automatic result_type mk_reply(input logic [7:0] rb);
      result_type r;
      r               = '0;
      r.reply_valid   = 1'b1;
      r.reply_byte    = rb;
      r.flash_cmd     = FC_NONE;
      return r;
   endfunction

   // Burst echo: length, start address, end address (bits 15:0, high first), CR.
   function automatic tail_type burst_echo(input logic [7:0] blen,
                                           input logic [ADDR_W-1:0] start_addr,
                                           input logic [ADDR_W-1:0] end_addr);
      tail_type t;
      t    = '0;
      t[0] = blen;
      t[1] = start_addr[15:8];
      t[2] = start_addr[7:0];
      t[3] = end_addr[15:8];
      t[4] = end_addr[7:0];
      t[5] = RPL_CR;
      return t;
   endfunction

endpackage

[design/slfl_parser.sv]
// Command parser: keeps the pending command and argument state, turns each byte into a
// result descriptor held in a one-entry register. Depends on slfl_pkg.
module slfl_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic [7:0]         rx_byte,
   input  logic               desc_take,
   output slfl_pkg::desc_type desc
);
   import slfl_pkg::*;

   typedef enum logic [2:0] {
      PC_IDLE, PC_ADDR, PC_LOW, PC_HIGH, PC_BLEN, PC_BDATA, PC_SKIP
   } pend_type;

   pend_type          pend_ff, pend_in;
   logic              idx_ff, idx_in;
   logic [ADDR_W-1:0] addr_ff, addr_in;
   logic [7:0]        low_ff, low_in;
   logic [7:0]        hi_ff, hi_in;
   logic [7:0]        blen_ff, blen_in;
   logic [7:0]        brem_ff, brem_in;
   logic [ADDR_W-1:0] bstart_ff, bstart_in;
   desc_type          desc_ff, desc_in;

   desc_type          d;
   logic [ADDR_W-1:0] addr_inc;
   logic [7:0]        brem_dec;

   assign addr_inc = addr_ff + ADDR_W'(2);
   assign brem_dec = brem_ff - 8'd1;

   always_comb begin
      pend_in   = pend_ff;
      idx_in    = idx_ff;
      addr_in   = addr_ff;
      low_in    = low_ff;
      hi_in     = hi_ff;
      blen_in   = blen_ff;
      brem_in   = brem_ff;
      bstart_in = bstart_ff;
      d         = '0;
      if (accept) begin
         case (pend_ff)
            PC_ADDR: begin
               if (!idx_ff) begin
                  hi_in  = rx_byte;
                  idx_in = 1'b1;
               end else begin
                  addr_in = {hi_ff, rx_byte, 1'b0};
                  idx_in  = 1'b0;
                  pend_in = PC_IDLE;
                  d.valid = 1'b1;
                  d.head  = mk_reply(RPL_CR);
               end
            end
            PC_LOW: begin
               low_in  = rx_byte;
               pend_in = PC_IDLE;
               d.valid = 1'b1;
               d.head  = mk_reply(RPL_CR);
            end
            PC_HIGH: begin
               d.valid              = 1'b1;
               d.head               = mk_reply(RPL_CR);
               d.head.flash_cmd     = FC_FILL;
               d.head.flash_address = addr_ff;
               d.head.flash_word    = {rx_byte, low_ff};
               addr_in              = addr_inc;
               pend_in              = PC_IDLE;
            end
            PC_BLEN: begin
               blen_in   = rx_byte;
               brem_in   = rx_byte;
               bstart_in = addr_ff;
               idx_in    = 1'b0;
               if (rx_byte == 8'd0) begin
                  // empty burst: echo at once, the length itself leads
                  pend_in    = PC_IDLE;
                  d.valid    = 1'b1;
                  d.head     = mk_reply(rx_byte);
                  d.tail     = burst_echo(rx_byte, addr_ff, addr_ff) >> 8;
                  d.tail_cnt = TCNT_W'(TAIL_MAX - 1);
               end else begin
                  pend_in = PC_BDATA;
               end
            end
            PC_BDATA: begin
               if (!idx_ff) begin
                  low_in = rx_byte;
                  idx_in = 1'b1;
               end else begin
                  idx_in               = 1'b0;
                  d.valid              = 1'b1;
                  d.head.flash_cmd     = FC_FILL;
                  d.head.flash_address = addr_ff;
                  d.head.flash_word    = {rx_byte, low_ff};
                  addr_in              = addr_inc;
                  brem_in              = brem_dec;
                  if (brem_dec == 8'd0) begin
                     pend_in    = PC_IDLE;
                     d.tail     = burst_echo(blen_ff, bstart_ff, addr_inc);
                     d.tail_cnt = TCNT_W'(TAIL_MAX);
                  end
               end
            end
            PC_SKIP: begin
               pend_in = PC_IDLE;
               d.valid = 1'b1;
               d.head  = mk_reply(RPL_CR);
            end
            default: begin
               pend_in = PC_IDLE;
               idx_in  = 1'b0;
               d.valid = 1'b1;
               d.head  = mk_reply(RPL_UNKNOWN);
               case (rx_byte)
                  CMD_SET_ADDR: begin
                     pend_in = PC_ADDR;
                     d.valid = 1'b0;
                  end
                  CMD_LOW_BYTE: begin
                     pend_in = PC_LOW;
                     d.valid = 1'b0;
                  end
                  CMD_HIGH_BYTE: begin
                     pend_in = PC_HIGH;
                     d.valid = 1'b0;
                  end
                  CMD_BURST: begin
                     pend_in = PC_BLEN;
                     d.valid = 1'b0;
                  end
                  CMD_DEV_TYPE: begin
                     pend_in = PC_SKIP;
                     d.valid = 1'b0;
                  end
                  CMD_ERASE: begin
                     d.head               = mk_reply(RPL_CR);
                     d.head.flash_cmd     = FC_ERASE;
                     d.head.flash_address = APP_SIZE_ADDR;
                     addr_in              = APP_END_ADDR;
                  end
                  CMD_PAGE_WRITE: begin
                     d.head               = mk_reply(RPL_CR);
                     d.head.flash_cmd     = FC_PAGE_WRITE;
                     d.head.flash_address = addr_ff;
                  end
                  CMD_PROG_ENTER, CMD_PROG_LEAVE: begin
                     d.head = mk_reply(RPL_CR);
                  end
                  CMD_AUTO_INC, CMD_BLOCK_SUP: begin
                     d.head = mk_reply(RPL_YES);
                  end
                  CMD_SW_IDENT: begin
                     d.head     = mk_reply(SW_IDENT[0]);
                     d.tail     = SW_IDENT[6:1];
                     d.tail_cnt = TCNT_W'(TAIL_MAX);
                  end
                  CMD_SIGNATURE: begin
                     d.head     = mk_reply(RPL_SIG0);
                     d.tail[0]  = RPL_SIG1;
                     d.tail[1]  = RPL_SIG2;
                     d.tail_cnt = TCNT_W'(2);
                  end
                  CMD_DEV_LIST: begin
                     d.head     = mk_reply(RPL_DEV_ID);
                     d.tail[0]  = 8'h00;
                     d.tail_cnt = TCNT_W'(1);
                  end
                  CMD_SW_VER: begin
                     d.head     = mk_reply(8'h32);
                     d.tail[0]  = 8'h34;
                     d.tail_cnt = TCNT_W'(1);
                  end
                  CMD_HW_VER: begin
                     d.head     = mk_reply(8'h31);
                     d.tail[0]  = 8'h30;
                     d.tail_cnt = TCNT_W'(1);
                  end
                  CMD_START_APP: begin
                     d.head           = '0;
                     d.head.flash_cmd = FC_START_APP;
                  end
                  default: begin
                     d.head = mk_reply(RPL_UNKNOWN);
                  end
               endcase
            end
         endcase
      end
      // load a new descriptor, else drop the one the emitter just took
      if (d.valid) begin
         desc_in = d;
      end else begin
         desc_in       = desc_ff;
         desc_in.valid = desc_ff.valid && !desc_take;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff   <= PC_IDLE;
         idx_ff    <= 1'b0;
         addr_ff   <= '0;
         low_ff    <= '0;
         hi_ff     <= '0;
         blen_ff   <= '0;
         brem_ff   <= '0;
         bstart_ff <= '0;
         desc_ff   <= '0;
      end else begin
         pend_ff   <= pend_in;
         idx_ff    <= idx_in;
         addr_ff   <= addr_in;
         low_ff    <= low_in;
         hi_ff     <= hi_in;
         blen_ff   <= blen_in;
         brem_ff   <= brem_in;
         bstart_ff <= bstart_in;
         desc_ff   <= desc_in;
      end
   end

   assign desc = desc_ff;

   a_burst_not_empty: assert property (@(posedge clock) disable iff (reset)
      pend_ff == PC_BDATA |-> brem_ff != 8'd0)
      else $error("burst data pending with zero words left");

   a_index_owner: assert property (@(posedge clock) disable iff (reset)
      idx_ff |-> (pend_ff == PC_ADDR || pend_ff == PC_BDATA))
      else $error("argument index set outside a two-byte argument");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      desc_ff.valid && !desc_take |=> desc_ff.valid)
      else $error("pending descriptor lost before the emitter took it");

endmodule

[design/slfl_emitter.sv]
// Result emitter: takes one descriptor at a time and sends its head result, then its
// reply bytes, one per cycle while rsp_stall is low, through the output register. Depends on slfl_pkg.
module slfl_emitter (
   input  logic                        clock,
   input  logic                        reset,
   input  slfl_pkg::desc_type          desc,
   output logic                        desc_take,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_reply_valid,
   output logic [7:0]                  rsp_reply_byte,
   output logic [2:0]                  rsp_flash_cmd,
   output logic [slfl_pkg::ADDR_W-1:0] rsp_flash_address,
   output logic [15:0]                 rsp_flash_word,
   output logic                        rsp_last
);
   import slfl_pkg::*;

   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, out_in;
   tail_type          tail_ff, tail_in;
   logic [TCNT_W-1:0] tcnt_ff, tcnt_in;
   logic              take;
   logic              free;

   assign take      = out_valid_ff && !rsp_stall;
   assign free      = !out_valid_ff || take;
   assign desc_take = desc.valid && free && (!out_valid_ff || tcnt_ff == '0);

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      tail_in      = tail_ff;
      tcnt_in      = tcnt_ff;
      if (free) begin
         if (out_valid_ff && tcnt_ff != '0) begin
            // advance to the next reply byte
            out_in       = mk_reply(tail_ff[0]);
            tail_in      = tail_ff >> 8;
            tcnt_in      = tcnt_ff - TCNT_W'(1);
            out_valid_in = 1'b1;
         end else if (desc.valid) begin
            out_in       = desc.head;
            tail_in      = desc.tail;
            tcnt_in      = desc.tail_cnt;
            out_valid_in = 1'b1;
         end else begin
            out_valid_in = 1'b0;
            tcnt_in      = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         out_ff       <= '0;
         tail_ff      <= '0;
         tcnt_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         out_ff       <= out_in;
         tail_ff      <= tail_in;
         tcnt_ff      <= tcnt_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_reply_valid   = out_ff.reply_valid;
   assign rsp_reply_byte    = out_ff.reply_byte;
   assign rsp_flash_cmd     = out_ff.flash_cmd;
   assign rsp_flash_address = out_ff.flash_address;
   assign rsp_flash_word    = out_ff.flash_word;
   assign rsp_last          = tcnt_ff == '0;

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !out_valid_ff |-> tcnt_ff == '0)
      else $error("reply bytes left with the output register empty");

   a_tail_continues: assert property (@(posedge clock) disable iff (reset)
      take && tcnt_ff != '0 |=> out_valid_ff && out_ff.reply_valid)
      else $error("reply sequence broken off");

   a_take_when_done: assert property (@(posedge clock) disable iff (reset)
      desc_take |-> (!out_valid_ff || (take && tcnt_ff == '0)))
      else $error("descriptor taken while a sequence is still in flight");

endmodule

[design/serial_flash_loader_command_parser_top.sv]
// Serial flash loader command parser, top level: parser plus result emitter.
// A result passes the parser's descriptor register, then the emitter's output register.
// One byte per cycle while req_stall is low; a byte's results leave one by one.
// The one-entry descriptor register lets the next byte in while a result waits.
// Reset (synchronous, active high) returns the parser to idle and clears address state.
// Depends on slfl_pkg, slfl_parser and slfl_emitter.
module serial_flash_loader_command_parser_top (
   input  logic                        clock,
   input  logic                        reset,
   // input words: one received byte each
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_rx_byte,
   // result words
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_reply_valid,
   output logic [7:0]                  rsp_reply_byte,
   output logic [2:0]                  rsp_flash_cmd,
   output logic [slfl_pkg::ADDR_W-1:0] rsp_flash_address,
   output logic [15:0]                 rsp_flash_word,
   output logic                        rsp_last
);
   import slfl_pkg::*;

   desc_type desc;
   logic     desc_take;
   logic     accept;

   // Hold off a new byte only while the descriptor slot is full and not moving on.
   assign req_stall = desc.valid && !desc_take;
   assign accept    = req_valid && !req_stall;

   // Parse: command state machine and argument registers.
   slfl_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_rx_byte),
      .desc_take (desc_take),
      .desc      (desc)
   );

   // Emit: serialize each descriptor into result words.
   slfl_emitter u_emitter (
      .clock             (clock),
      .reset             (reset),
      .desc              (desc),
      .desc_take         (desc_take),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reply_valid   (rsp_reply_valid),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_flash_cmd     (rsp_flash_cmd),
      .rsp_flash_address (rsp_flash_address),
      .rsp_flash_word    (rsp_flash_word),
      .rsp_last          (rsp_last)
   );

endmodule

[bench/tb_serial_flash_loader_command_parser_top.sv]
// Self-checking testbench for the serial flash loader command parser top level.
// Needs slfl_pkg for geometry, command codes and reply bytes, and the RTL top module.
module tb_serial_flash_loader_command_parser_top;
   timeunit 1ns;
   timeprecision 1ps;

   import slfl_pkg::*;

   localparam int CLOCK_PERIOD    = 12;
   localparam int RESET_CYCLES    = 8;
   localparam int SETTLE_CYCLES   = 16;
   localparam int REPORT_LIMIT    = 10;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int RANDOM_WORDS    = 240;
   localparam int MAX_GAP         = 24;
   localparam int TIMEOUT_CYCLES  = 400000;

   // Application area as the loader sees it: flash below the boot section.
   localparam int LOADER_BYTES  = 2 * LOADER_WORDS;
   localparam int APP_BYTES     = (LOADER_BYTES > FLASH_BYTES) ? 0 : FLASH_BYTES - LOADER_BYTES;
   localparam int APP_PAGED_END = ((APP_BYTES + PAGE_BYTES - 1) / PAGE_BYTES) * PAGE_BYTES;

   // Fixed reply text: identifier, device list terminator, version digits.
   localparam logic [0:6][7:0] IDENT_TEXT = {8'h41, 8'h56, 8'h52, 8'h42, 8'h4F, 8'h4F, 8'h54};
   localparam logic [7:0] DEV_LIST_END = 8'h00;
   localparam logic [7:0] SW_VER_MAJOR = 8'h32;
   localparam logic [7:0] SW_VER_MINOR = 8'h34;
   localparam logic [7:0] HW_VER_MAJOR = 8'h31;
   localparam logic [7:0] HW_VER_MINOR = 8'h30;

   typedef enum logic [2:0] {
      WAIT_CMD, WAIT_ADDR, WAIT_LOW, WAIT_HIGH, WAIT_BLEN, WAIT_PAIR, WAIT_SKIP
   } parse_state_type;

   typedef struct packed {
      logic              reply_valid;
      logic [7:0]        reply_byte;
      flash_cmd_type     flash_cmd;
      logic [ADDR_W-1:0] flash_address;
      logic [15:0]       flash_word;
      logic              last;
   } loader_word_type;

   logic              clock;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   logic [7:0]        req_rx_byte = 8'h00;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   logic              rsp_reply_valid;
   logic [7:0]        rsp_reply_byte;
   logic [2:0]        rsp_flash_cmd;
   logic [ADDR_W-1:0] rsp_flash_address;
   logic [15:0]       rsp_flash_word;
   logic              rsp_last;

   // Parser state as the host protocol defines it.
   parse_state_type   parse_state;
   logic              second_arg;
   logic [ADDR_W-1:0] flash_ptr;
   logic [7:0]        data_low;
   logic [7:0]        addr_high;
   logic [7:0]        burst_len;
   logic [7:0]        burst_left;
   logic [ADDR_W-1:0] burst_start;

   loader_word_type reply_words_due[$];

   int fail_count    = 0;
   int sent_words    = 0;
   int snd_idle_pct  = 0;
   int rcv_idle_pct  = 0;
   int hold_off_asks = 0;

   serial_flash_loader_command_parser_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_rx_byte       (req_rx_byte),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_reply_valid   (rsp_reply_valid),
      .rsp_reply_byte    (rsp_reply_byte),
      .rsp_flash_cmd     (rsp_flash_cmd),
      .rsp_flash_address (rsp_flash_address),
      .rsp_flash_word    (rsp_flash_word),
      .rsp_last          (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // Guard against a hung handshake: end the run well past the slowest correct finish.
   initial begin
      #(CLOCK_PERIOD * TIMEOUT_CYCLES);
      $display("tb_serial_flash_loader_command_parser_top: FAIL");
      $finish;
   end

   // ---------------------------------------------------------------- prediction

   function void clear_parser_state();
      parse_state = WAIT_CMD;
      second_arg  = 1'b0;
      flash_ptr   = '0;
      data_low    = '0;
      addr_high   = '0;
      burst_len   = '0;
      burst_left  = '0;
      burst_start = '0;
   endfunction

   function void queue_word(input logic rv, input logic [7:0] rb, input flash_cmd_type fc,
                            input logic [ADDR_W-1:0] fa, input logic [15:0] fw);
      loader_word_type w;
      w.reply_valid   = rv;
      w.reply_byte    = rb;
      w.flash_cmd     = fc;
      w.flash_address = fa;
      w.flash_word    = fw;
      w.last          = 1'b0;
      reply_words_due.push_back(w);
   endfunction

   function void queue_reply(input logic [7:0] rb);
      queue_word(1'b1, rb, FC_NONE, '0, '0);
   endfunction

   // Burst echo sends only address bits 15:0, so bit 16 never reaches the host.
   function void queue_burst_echo();
      queue_reply(burst_len);
      queue_reply(burst_start[15:8]);
      queue_reply(burst_start[7:0]);
      queue_reply(flash_ptr[15:8]);
      queue_reply(flash_ptr[7:0]);
      queue_reply(RPL_CR);
   endfunction

   // Advance the parser by one received byte and queue every result word it causes.
   function void parse_rx_byte(input logic [7:0] b);
      int queued_before;
      queued_before = reply_words_due.size();
      case (parse_state)
         WAIT_ADDR: begin
            if (!second_arg) begin
               addr_high  = b;
               second_arg = 1'b1;
            end else begin
               flash_ptr   = {addr_high, b, 1'b0};
               second_arg  = 1'b0;
               parse_state = WAIT_CMD;
               queue_reply(RPL_CR);
            end
         end
         WAIT_LOW: begin
            data_low    = b;
            parse_state = WAIT_CMD;
            queue_reply(RPL_CR);
         end
         WAIT_HIGH: begin
            queue_word(1'b1, RPL_CR, FC_FILL, flash_ptr, {b, data_low});
            flash_ptr   = flash_ptr + ADDR_W'(2);
            parse_state = WAIT_CMD;
         end
         WAIT_BLEN: begin
            burst_len   = b;
            burst_left  = b;
            burst_start = flash_ptr;
            second_arg  = 1'b0;
            if (b == 8'd0) begin
               parse_state = WAIT_CMD;
               queue_burst_echo();
            end else begin
               parse_state = WAIT_PAIR;
            end
         end
         WAIT_PAIR: begin
            if (!second_arg) begin
               data_low   = b;
               second_arg = 1'b1;
            end else begin
               second_arg = 1'b0;
               queue_word(1'b0, 8'h00, FC_FILL, flash_ptr, {b, data_low});
               flash_ptr  = flash_ptr + ADDR_W'(2);
               burst_left = burst_left - 8'd1;
               if (burst_left == 8'd0) begin
                  parse_state = WAIT_CMD;
                  queue_burst_echo();
               end
            end
         end
         WAIT_SKIP: begin
            parse_state = WAIT_CMD;
            queue_reply(RPL_CR);
         end
         default: begin
            parse_state = WAIT_CMD;
            second_arg  = 1'b0;
            case (b)
               CMD_SET_ADDR:  parse_state = WAIT_ADDR;
               CMD_LOW_BYTE:  parse_state = WAIT_LOW;
               CMD_HIGH_BYTE: parse_state = WAIT_HIGH;
               CMD_BURST:     parse_state = WAIT_BLEN;
               CMD_DEV_TYPE:  parse_state = WAIT_SKIP;
               CMD_ERASE: begin
                  queue_word(1'b1, RPL_CR, FC_ERASE, ADDR_W'(APP_BYTES), '0);
                  flash_ptr = ADDR_W'(APP_PAGED_END);
               end
               CMD_PAGE_WRITE: queue_word(1'b1, RPL_CR, FC_PAGE_WRITE, flash_ptr, '0);
               CMD_PROG_ENTER, CMD_PROG_LEAVE: queue_reply(RPL_CR);
               CMD_AUTO_INC, CMD_BLOCK_SUP:    queue_reply(RPL_YES);
               CMD_SW_IDENT: begin
                  for (int i = 0; i < 7; i++) queue_reply(IDENT_TEXT[i]);
               end
               CMD_SIGNATURE: begin
                  queue_reply(RPL_SIG0);
                  queue_reply(RPL_SIG1);
                  queue_reply(RPL_SIG2);
               end
               CMD_DEV_LIST: begin
                  queue_reply(RPL_DEV_ID);
                  queue_reply(DEV_LIST_END);
               end
               CMD_SW_VER: begin
                  queue_reply(SW_VER_MAJOR);
                  queue_reply(SW_VER_MINOR);
               end
               CMD_HW_VER: begin
                  queue_reply(HW_VER_MAJOR);
                  queue_reply(HW_VER_MINOR);
               end
               CMD_START_APP: queue_word(1'b0, 8'h00, FC_START_APP, '0, '0);
               default:       queue_reply(RPL_UNKNOWN);
            endcase
         end
      endcase
      // Flag the final word of this byte's results.
      if (reply_words_due.size() > queued_before)
         reply_words_due[reply_words_due.size() - 1].last = 1'b1;
   endfunction

   // ---------------------------------------------------------------- checking

   function void report_failure(input string why, input loader_word_type want,
                                input loader_word_type seen);
      fail_count++;
      if (fail_count <= REPORT_LIMIT) begin
         $display("%t %s: expected rv=%0b byte=%h cmd=%0d addr=%h word=%h last=%0b",
                  $realtime, why,
                  want.reply_valid, want.reply_byte, want.flash_cmd, want.flash_address,
                  want.flash_word, want.last);
         $display("   got rv=%0b byte=%h cmd=%0d addr=%h word=%h last=%0b",
                  seen.reply_valid, seen.reply_byte, seen.flash_cmd, seen.flash_address,
                  seen.flash_word, seen.last);
      end
   endfunction

   // Sample mid-cycle: a word that is valid and not stalled here is taken at the next edge.
   always @(negedge clock) begin : check_result_words
      loader_word_type seen;
      loader_word_type want;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         seen.reply_valid   = rsp_reply_valid;
         seen.reply_byte    = rsp_reply_byte;
         seen.flash_cmd     = flash_cmd_type'(rsp_flash_cmd);
         seen.flash_address = rsp_flash_address;
         seen.flash_word    = rsp_flash_word;
         seen.last          = rsp_last;
         if (reply_words_due.size() == 0) begin
            report_failure("result word with nothing pending", '0, seen);
         end else begin
            want = reply_words_due.pop_front();
            if (seen !== want) report_failure("result word mismatch", want, seen);
         end
      end
   end

   // ---------------------------------------------------------------- result side

   // Drive rsp_stall: random stalls at the current rate, or a long hold-off when asked.
   initial begin : drive_rsp_stall
      int hold_left;
      int asks_seen;
      hold_left = 0;
      asks_seen = 0;
      forever begin
         @(posedge clock);
         if (hold_off_asks != asks_seen) begin
            asks_seen = hold_off_asks;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rcv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------- input side

   // Offer one byte after a random idle gap and hold it until the block takes it.
   // Leave req_valid high on return; the next call or drain_results decides.
   task automatic send_rx_byte(input logic [7:0] b);
      int gap;
      bit taken;
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(99) < snd_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do begin
         @(negedge clock);
         taken = (req_stall === 1'b0);
         if (taken) parse_rx_byte(b);
         @(posedge clock);
      end while (!taken);
      sent_words++;
   endtask

   task automatic send_random_byte();
      send_rx_byte(8'($urandom_range(255)));
   endtask

   // Drop valid, wait for every pending result word, then let the pipeline settle.
   task automatic drain_results();
      req_valid <= 1'b0;
      while (reply_words_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   // Every single-byte command but erase and page write, plus unknown codes at both ends of the byte range.
   task automatic test_single_byte_commands();
      send_rx_byte(CMD_PROG_ENTER);
      send_rx_byte(CMD_PROG_LEAVE);
      send_rx_byte(CMD_AUTO_INC);
      send_rx_byte(CMD_BLOCK_SUP);
      send_rx_byte(CMD_SW_IDENT);
      send_rx_byte(CMD_SIGNATURE);
      send_rx_byte(CMD_DEV_LIST);
      send_rx_byte(CMD_SW_VER);
      send_rx_byte(CMD_HW_VER);
      send_rx_byte(CMD_START_APP);
      send_rx_byte(8'h00);
      send_rx_byte(8'hFF);
   endtask

   // Top address, two fills (the byte address wraps to zero after the first), and a command code
   // taken as a plain argument while the address command waits.
   task automatic test_address_and_fill();
      send_rx_byte(CMD_SET_ADDR);
      send_rx_byte(8'hFF);
      send_rx_byte(8'hFF);
      send_rx_byte(CMD_LOW_BYTE);
      send_rx_byte(8'hAA);
      send_rx_byte(CMD_HIGH_BYTE);
      send_rx_byte(8'h55);
      send_rx_byte(CMD_HIGH_BYTE);
      send_rx_byte(8'h00);
      send_rx_byte(CMD_SET_ADDR);
      send_rx_byte(CMD_START_APP);
      send_rx_byte(CMD_ERASE);
      send_rx_byte(CMD_DEV_TYPE);
      send_rx_byte(8'hFF);
   endtask

   task automatic test_erase_and_page_write();
      send_rx_byte(CMD_ERASE);
      send_rx_byte(CMD_PAGE_WRITE);
   endtask

   // Empty burst, then a burst starting at 64 KiB so the echo loses bit 16.
   task automatic test_burst_writes();
      send_rx_byte(CMD_BURST);
      send_rx_byte(8'h00);
      send_rx_byte(CMD_SET_ADDR);
      send_rx_byte(8'h80);
      send_rx_byte(8'h00);
      send_rx_byte(CMD_BURST);
      send_rx_byte(8'h01);
      send_rx_byte(8'h11);
      send_rx_byte(8'h22);
   endtask

   // Hold the result side for a long stretch while bytes with long replies keep
   // coming, so the block fills and stalls its input.
   task automatic test_input_back_pressure();
      drain_results();
      @(negedge clock);
      hold_off_asks++;
      @(posedge clock);
      repeat (12) send_rx_byte(CMD_SW_IDENT);
      repeat (4) send_rx_byte(CMD_SIGNATURE);
      drain_results();
   endtask

   // Mostly well-formed command sequences with random arguments, some noise and
   // some cut-short sequences that leave argument bytes to be misread as commands.
   task automatic test_random_traffic(input int count);
      int stop_at;
      int pick;
      int pairs;
      stop_at = sent_words + count;
      while (sent_words < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 8) begin
            send_random_byte();
         end else if (pick < 14) begin
            // cut-short sequence: a command with too few argument bytes
            case ($urandom_range(3))
               0: send_rx_byte(CMD_SET_ADDR);
               1: send_rx_byte(CMD_HIGH_BYTE);
               2: begin
                  send_rx_byte(CMD_BURST);
                  send_rx_byte(8'($urandom_range(1, 4)));
               end
               default: send_rx_byte(CMD_DEV_TYPE);
            endcase
            repeat ($urandom_range(2)) send_random_byte();
         end else begin
            case ($urandom_range(15))
               0: begin
                  send_rx_byte(CMD_SET_ADDR);
                  send_random_byte();
                  send_random_byte();
               end
               1: begin
                  send_rx_byte(CMD_LOW_BYTE);
                  send_random_byte();
                  send_rx_byte(CMD_HIGH_BYTE);
                  send_random_byte();
               end
               2: begin
                  send_rx_byte(CMD_HIGH_BYTE);
                  send_random_byte();
               end
               3, 4: begin
                  pairs = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
                  send_rx_byte(CMD_BURST);
                  send_rx_byte(8'(pairs));
                  repeat (2 * pairs) send_random_byte();
               end
               5: begin
                  send_rx_byte(CMD_DEV_TYPE);
                  send_random_byte();
               end
               6:  send_rx_byte(CMD_ERASE);
               7:  send_rx_byte(CMD_PAGE_WRITE);
               8:  send_rx_byte($urandom_range(1) ? CMD_PROG_ENTER : CMD_PROG_LEAVE);
               9:  send_rx_byte($urandom_range(1) ? CMD_AUTO_INC : CMD_BLOCK_SUP);
               10: send_rx_byte(CMD_SW_IDENT);
               11: send_rx_byte(CMD_SIGNATURE);
               12: send_rx_byte(CMD_DEV_LIST);
               13: send_rx_byte($urandom_range(1) ? CMD_SW_VER : CMD_HW_VER);
               14: send_rx_byte(CMD_START_APP);
               default: send_random_byte();
            endcase
         end
      end
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      clear_parser_state();
      // Phase one: sender idles often, receiver stalls most of the time.
      snd_idle_pct = 36;
      rcv_idle_pct = 77;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      test_single_byte_commands();
      test_address_and_fill();
      test_erase_and_page_write();
      test_burst_writes();
      drain_results();
      test_random_traffic(RANDOM_WORDS / 3);
      drain_results();

      // Phase two: swap the idle rates.
      snd_idle_pct = 77;
      rcv_idle_pct = 36;
      test_random_traffic(RANDOM_WORDS / 3);
      drain_results();

      // Phase three: no idling on either side, then the long hold-off.
      snd_idle_pct = 0;
      rcv_idle_pct = 0;
      test_random_traffic(RANDOM_WORDS / 3);
      test_input_back_pressure();
      drain_results();

      if (fail_count == 0 && reply_words_due.size() == 0)
         $display("tb_serial_flash_loader_command_parser_top: PASS");
      else
         $display("tb_serial_flash_loader_command_parser_top: FAIL");
      $finish;
   end

endmodule
